/* hdl/delta_timer_queue_assert.svh */
// Assertion macros for the delta timer queue.
// Used by files that include this header; no other dependencies.
`ifndef DELTA_TIMER_QUEUE_ASSERT_SVH
`define DELTA_TIMER_QUEUE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define DTQ_ASSERT_IMP(label, lhs, rhs, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (lhs) |-> (rhs)) \
        else $error(msg);
// Implication checked in the next cycle.
`define DTQ_ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

/* hdl/dtq_pkg.sv */
// Shared codes for the delta timer queue.
// No dependencies.
`default_nettype none
package dtq_pkg;
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] KIND_DONE    = 2'd0;
    localparam logic [1:0] KIND_REJECT  = 2'd1;
    localparam logic [1:0] KIND_NOEXP   = 2'd2;
    localparam logic [1:0] KIND_EXPIRED = 2'd3;

    localparam int ID_WIDTH = 4;
    localparam int MAX_RESULTS = 16;

    // One result word as handed to the output register.
    typedef struct packed {
        logic [1:0]          kind;
        logic [ID_WIDTH-1:0] id;
        logic                last;
    } result_t;
endpackage
`default_nettype wire

/* hdl/delta_timer_queue.sv */
// Delta-list timer queue: one word in, one or more result words out. Add and
// tick walk the list one entry per read of the entry memory. An add passes each
// entry in issue, wait and compare states, then writes the new entry and
// patches its predecessor's next link. A delete reads the entry, then patches
// its prev and next neighbors. A tick examines the head and unlinks expired
// timers. Rejected adds, deletes of idle timers and ticks on an empty list go
// straight to the output register.
// Result words wait in an output register, and the next word is taken once the
// last result word of the previous item has been accepted. No clearing pass is
// needed after reset.
`default_nettype none
module delta_timer_queue #(
    parameter int NUM_TIMERS  = 16,
    parameter int DELTA_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: op[1:0], timer_id[5:2], delay[37:6], zero fill to 40 bits
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: result_kind[1:0], expired_id[5:2], zero fill to 8 bits
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);
    import dtq_pkg::*;

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int LW = $clog2(NUM_TIMERS + 1);
    localparam int EW = DELTA_WIDTH + 2 * LW;
    localparam logic [LW-1:0] NIL = LW'(NUM_TIMERS);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_AWAIT  = 4'd1;
    localparam logic [3:0] ST_ACHK   = 4'd2;
    localparam logic [3:0] ST_AINS   = 4'd3;
    localparam logic [3:0] ST_APREV  = 4'd4;
    localparam logic [3:0] ST_ANXT   = 4'd5;
    localparam logic [3:0] ST_UREAD  = 4'd6;
    localparam logic [3:0] ST_UWAIT  = 4'd7;
    localparam logic [3:0] ST_UPREV  = 4'd8;
    localparam logic [3:0] ST_UNXT   = 4'd9;
    localparam logic [3:0] ST_UFIN   = 4'd10;
    localparam logic [3:0] ST_TWAIT  = 4'd11;
    localparam logic [3:0] ST_TCHK   = 4'd12;
    localparam logic [3:0] ST_OUT    = 4'd13;
    localparam logic [3:0] ST_AREAD  = 4'd14;

    logic [3:0]             state_reg, state_next;
    logic [NUM_TIMERS-1:0]  queued_reg, queued_next;
    logic [LW-1:0]          head_reg, head_next;
    logic [1:0]             op_reg, op_next;
    logic [LW-1:0]          id_reg, id_next;
    logic [DELTA_WIDTH-1:0] d_reg, d_next;
    logic [LW-1:0]          prev_reg, prev_next;
    logic [LW-1:0]          cur_reg, cur_next;
    logic [LW-1:0]          unl_p_reg, unl_p_next;
    logic [LW-1:0]          unl_n_reg, unl_n_next;
    logic [DELTA_WIDTH-1:0] unl_d_reg, unl_d_next;
    logic [4:0]             cnt_reg, cnt_next;
    logic                   first_reg, first_next;
    logic                   ovalid_reg, ovalid_next;
    result_t                obuf_reg, obuf_next;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [EW-1:0]          wr_data, rd_data;
    logic [DELTA_WIDTH-1:0] rd_delta;
    logic [DELTA_WIDTH-1:0] fold_delta;
    logic [LW-1:0]          rd_nl, rd_pl;
    logic                   out_free;
    logic [1:0]             in_op;
    logic [3:0]             in_id;
    logic [LW-1:0]          in_slot;
    logic [DELTA_WIDTH-1:0] in_delay;
    logic [31:0]            in_delay32;

    assign rd_delta = rd_data[EW-1 -: DELTA_WIDTH];
    assign rd_nl    = rd_data[2*LW-1:LW];
    assign rd_pl    = rd_data[LW-1:0];
    // follower's delta with the removed entry's delta folded in
    assign fold_delta = rd_delta + unl_d_reg;

    assign in_op      = s_tdata[1:0];
    assign in_id      = s_tdata[5:2];
    assign in_slot    = LW'(in_id);
    assign in_delay32 = s_tdata[37:6];
    if (DELTA_WIDTH >= 32) begin : g_dwide
        assign in_delay = DELTA_WIDTH'(in_delay32);
    end else begin : g_dnarrow
        assign in_delay = in_delay32[DELTA_WIDTH-1:0];
    end

    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {2'b00, obuf_reg.id, obuf_reg.kind};
    assign m_tlast  = obuf_reg.last;

    dtq_entry_mem #(.DEPTH(NUM_TIMERS), .DW(DELTA_WIDTH), .LW(LW)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer: reads one entry, then modifies and writes back
    always_comb begin
        state_next  = state_reg;
        queued_next = queued_reg;
        head_next   = head_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        d_next      = d_reg;
        prev_next   = prev_reg;
        cur_next    = cur_reg;
        unl_p_next  = unl_p_reg;
        unl_n_next  = unl_n_reg;
        unl_d_next  = unl_d_reg;
        cnt_next    = cnt_reg;
        first_next  = first_reg;
        ovalid_next = ovalid_reg && !m_tready;
        obuf_next   = obuf_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        rd_addr     = cur_reg[AW-1:0];
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && !ovalid_reg) begin
                    op_next    = in_op;
                    id_next    = in_slot;
                    d_next     = in_delay;
                    prev_next  = NIL;
                    cur_next   = head_reg;
                    cnt_next   = '0;
                    first_next = 1'b1;
                    if (in_op == OP_ADD) begin
                        if (in_id >= 4'(NUM_TIMERS < 16 ? NUM_TIMERS : 15)
                                && NUM_TIMERS < 16 || in_delay == '0
                                || queued_reg[in_slot[AW-1:0]]) begin
                            obuf_next  = '{kind: KIND_REJECT, id: '0, last: 1'b1};
                            state_next = ST_OUT;
                        end else begin
                            state_next = ST_AREAD;
                        end
                    end else if (in_op == OP_DEL) begin
                        if ((NUM_TIMERS >= 16 || in_id < 4'(NUM_TIMERS))
                                && queued_reg[in_slot[AW-1:0]]) begin
                            cur_next   = in_slot;
                            state_next = ST_UREAD;
                        end else begin
                            obuf_next  = '{kind: KIND_DONE, id: '0, last: 1'b1};
                            state_next = ST_OUT;
                        end
                    end else if (in_op == OP_TICK && head_reg != NIL) begin
                        cur_next   = head_reg;
                        state_next = ST_TWAIT;
                    end else begin
                        obuf_next  = '{kind: KIND_NOEXP, id: '0, last: 1'b1};
                        state_next = ST_OUT;
                    end
                end
            end
            // Add walk: issue read of cur (or finish at end of list)
            ST_AREAD: begin
                if (cur_reg == NIL) begin
                    state_next = ST_AINS;
                end else begin
                    state_next = ST_AWAIT;
                end
            end
            ST_AWAIT: state_next = ST_ACHK;
            ST_ACHK: begin
                if (d_reg < rd_delta) begin
                    wr_en      = 1'b1;
                    wr_addr    = cur_reg[AW-1:0];
                    wr_data    = {rd_delta - d_reg, rd_nl, id_reg};
                    state_next = ST_AINS;
                end else begin
                    d_next     = d_reg - rd_delta;
                    prev_next  = cur_reg;
                    cur_next   = rd_nl;
                    state_next = ST_AREAD;
                end
            end
            ST_AINS: begin
                wr_en       = 1'b1;
                wr_addr     = id_reg[AW-1:0];
                wr_data     = {d_reg, cur_reg, prev_reg};
                queued_next = queued_reg | (NUM_TIMERS'(1) << id_reg[AW-1:0]);
                if (prev_reg == NIL) begin
                    head_next  = id_reg;
                    obuf_next  = '{kind: KIND_DONE, id: '0, last: 1'b1};
                    state_next = ST_OUT;
                end else begin
                    rd_addr    = prev_reg[AW-1:0];
                    state_next = ST_APREV;
                end
            end
            // keep prev on the read port until its word is used
            ST_APREV: begin
                rd_addr    = prev_reg[AW-1:0];
                state_next = ST_ANXT;
            end
            ST_ANXT: begin
                wr_en      = 1'b1;
                wr_addr    = prev_reg[AW-1:0];
                wr_data    = {rd_delta, id_reg, rd_pl};
                obuf_next  = '{kind: KIND_DONE, id: '0, last: 1'b1};
                state_next = ST_OUT;
            end
            // Unlink cur: read it, then patch prev and next neighbors
            ST_UREAD: state_next = ST_UWAIT;
            ST_UWAIT: begin
                unl_p_next = rd_pl;
                unl_n_next = rd_nl;
                unl_d_next = rd_delta;
                rd_addr    = rd_pl[AW-1:0];
                queued_next = queued_reg & ~(NUM_TIMERS'(1) << cur_reg[AW-1:0]);
                if (rd_pl == NIL) begin
                    head_next = rd_nl;
                end
                state_next = ST_UPREV;
            end
            ST_UPREV: begin
                rd_addr = unl_n_reg[AW-1:0];
                if (unl_p_reg != NIL) begin
                    wr_en   = 1'b1;
                    wr_addr = unl_p_reg[AW-1:0];
                    wr_data = {rd_delta, unl_n_reg, rd_pl};
                end
                state_next = ST_UNXT;
            end
            ST_UNXT: begin
                // re-read next so its folded delta is visible in UFIN
                rd_addr = unl_n_reg[AW-1:0];
                if (unl_n_reg != NIL) begin
                    wr_en   = 1'b1;
                    wr_addr = unl_n_reg[AW-1:0];
                    wr_data = {fold_delta, rd_nl, unl_p_reg};
                end
                state_next = ST_UFIN;
            end
            ST_UFIN: begin
                if (op_reg == OP_DEL) begin
                    obuf_next  = '{kind: KIND_DONE, id: '0, last: 1'b1};
                    state_next = ST_OUT;
                end else if (out_free) begin
                    ovalid_next = 1'b1;
                    obuf_next   = '{kind: KIND_EXPIRED,
                                    id: ID_WIDTH'(cur_reg), last: 1'b0};
                    cnt_next    = cnt_reg + 5'd1;
                    cur_next    = head_reg;
                    // another expiry follows only if the new head is at zero
                    if (head_reg != NIL && fold_delta == '0
                            && cnt_reg != 5'(MAX_RESULTS - 1)) begin
                        state_next = ST_TWAIT;
                    end else begin
                        obuf_next.last = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            // Tick: examine the head, decrement once on first visit
            ST_TWAIT: state_next = ST_TCHK;
            ST_TCHK: begin
                first_next = 1'b0;
                if (first_reg && rd_delta != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = cur_reg[AW-1:0];
                    wr_data = {rd_delta - 1'b1, rd_nl, rd_pl};
                end
                if (rd_delta == '0 || (first_reg && rd_delta == DELTA_WIDTH'(1))) begin
                    state_next = ST_UREAD;
                end else begin
                    obuf_next  = '{kind: KIND_NOEXP, id: '0, last: 1'b1};
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            queued_reg <= '0;
            head_reg   <= NIL;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            queued_reg <= queued_next;
            head_reg   <= head_next;
            ovalid_reg <= ovalid_next;
        end
        op_reg    <= op_next;
        id_reg    <= id_next;
        d_reg     <= d_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        unl_p_reg <= unl_p_next;
        unl_n_reg <= unl_n_next;
        unl_d_reg <= unl_d_next;
        cnt_reg   <= cnt_next;
        first_reg <= first_next;
        obuf_reg  <= obuf_next;
    end

`include "delta_timer_queue_assert.svh"
    `DTQ_ASSERT_IMP(a_head_empty, head_reg == NIL, queued_reg == '0, "head nil with queued")
    `DTQ_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result word changed while stalled")
    `DTQ_ASSERT_NEXT(a_accept, s_tvalid && s_tready, !s_tready, "accepted twice")
    `DTQ_ASSERT_IMP(a_out_idle, s_tready, !m_tvalid, "input taken with result pending")
endmodule
`default_nettype wire

/* hdl/dtq_entry_mem.sv */
// Entry store of the timer queue: delta, next and prev link per slot.
// Depends on nothing; one write port, one registered read port.
`default_nettype none
module dtq_entry_mem #(
    parameter int DEPTH = 16,
    parameter int DW    = 32,
    parameter int LW    = 5
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DW+2*LW-1:0]       wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DW+2*LW-1:0]       rd_data
);
    logic [DW+2*LW-1:0] mem [DEPTH];

    // Synchronous write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire
